>>> design/csi_ksp_pkg.sv
package csi_ksp_pkg;

    localparam logic [7:0] ByteEsc   = 8'h1B;
    localparam logic [7:0] ByteLbrk  = 8'h5B;  // '['
    localparam logic [7:0] ByteColon = 8'h3A;
    localparam logic [7:0] ByteSemi  = 8'h3B;
    localparam logic [7:0] ByteZero  = 8'h30;
    localparam logic [7:0] ByteNine  = 8'h39;
    localparam logic [7:0] ByteTermU = 8'h75;  // 'u'

    localparam logic [2:0] PosMax   = 3'd7;
    localparam logic [2:0] PosBody  = 3'd2;
    localparam logic [2:0] PosMinOk = 3'd3;
    localparam logic [1:0] FieldMax = 2'd2;
    localparam logic [1:0] FieldKey = 2'd0;
    localparam logic [1:0] FieldMod = 2'd1;

    localparam logic [1:0] KindPress   = 2'd1;
    localparam logic [1:0] KindRelease = 2'd3;

    localparam int DataWidth = 48;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  modifier_bits;
        logic [31:0] key_code;
    } key_result_t;

    // fixed key codes for the functional-key terminators
    function automatic logic [31:0] term_code(input logic [7:0] b);
        logic [31:0] code;
        case (b)
            8'h41:   code = 32'd57417;  // A
            8'h42:   code = 32'd57420;  // B
            8'h43:   code = 32'd57421;  // C
            8'h44:   code = 32'd57419;  // D
            8'h48:   code = 32'd57423;  // H
            8'h46:   code = 32'd57424;  // F
            8'h50:   code = 32'd57364;  // P
            8'h51:   code = 32'd57365;  // Q
            8'h52:   code = 32'd57366;  // R
            8'h53:   code = 32'd57367;  // S
            default: code = 32'd0;
        endcase
        return code;
    endfunction

    function automatic logic is_func_term(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h48)) || ((b >= 8'h50) && (b <= 8'h53));
    endfunction

endpackage

>>> design/csi_key_sequence_parser_unit.sv
// a final byte goes into the input register, then parse logic loads the result register,
// which drives m_tvalid; a stalled result stage holds the byte in the input register
// throughput: one byte per cycle while the result stage is not stalled,
// set by the single decimal accumulate per byte
// non-final bytes produce no result transaction
// reset (aresetn low, synchronous): both stages empty, parser state cleared
module csi_key_sequence_parser_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic                              s_tlast,   // final_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csi_ksp_pkg::DataWidth-1:0] m_tdata,   // key_code, modifier_bits, event_kind
    output logic                              m_tuser    // seq_valid
);
    import csi_ksp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [2:0]  pos_reg, pos_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [1:0]  field_reg, field_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] mod_reg, mod_next;
    logic [31:0] sub_reg, sub_next;
    logic        has_sub_reg, has_sub_next;
    logic        in_sub_reg, in_sub_next;

    logic        out_valid_reg;
    logic        out_ok_reg, out_ok_next;
    key_result_t out_res_reg, out_res_next;

    logic        out_ready;
    logic        proc_fire;
    logic        is_digit;
    logic [31:0] acc_src;
    logic [31:0] acc_val;
    logic [7:0]  sub_low;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && out_ready;

    assign is_digit = (in_byte_reg >= ByteZero) && (in_byte_reg <= ByteNine);
    assign sub_low  = sub_reg[7:0];

    // one shared times-ten accumulate, source picked by the sub-parameter flag, then the current field
    always_comb begin
        if (in_sub_reg) begin
            acc_src = sub_reg;
        end else if (field_reg == FieldKey) begin
            acc_src = first_reg;
        end else begin
            acc_src = mod_reg;
        end
        acc_val = (acc_src << 3) + (acc_src << 1) + {28'd0, in_byte_reg[3:0]};
    end

    always_comb begin
        pos_next     = pos_reg;
        hdr_ok_next  = hdr_ok_reg;
        field_next   = field_reg;
        first_next   = first_reg;
        mod_next     = mod_reg;
        sub_next     = sub_reg;
        has_sub_next = has_sub_reg;
        in_sub_next  = in_sub_reg;
        out_ok_next  = 1'b0;
        out_res_next = '0;

        if ((pos_reg == 3'd0) && (in_byte_reg != ByteEsc)) begin
            hdr_ok_next = 1'b0;
        end
        if ((pos_reg == 3'd1) && (in_byte_reg != ByteLbrk)) begin
            hdr_ok_next = 1'b0;
        end

        if (!in_last_reg) begin
            if (pos_reg >= PosBody) begin
                if (is_digit) begin
                    if (in_sub_reg) begin
                        if (field_reg == FieldMod) begin
                            sub_next = acc_val;
                        end
                    end else if (field_reg == FieldKey) begin
                        first_next = acc_val;
                    end else if (field_reg == FieldMod) begin
                        mod_next = acc_val;
                    end
                end else if (in_byte_reg == ByteColon) begin
                    if (field_reg == FieldMod) begin
                        has_sub_next = 1'b1;
                    end
                    in_sub_next = 1'b1;
                end else if (in_byte_reg == ByteSemi) begin
                    if (field_reg < FieldMax) begin
                        field_next = field_reg + 2'd1;
                    end
                    in_sub_next = 1'b0;
                end
            end
            if (pos_reg < PosMax) begin
                pos_next = pos_reg + 3'd1;
            end
        end else begin
            out_ok_next = (pos_reg >= PosMinOk) && hdr_ok_next &&
                          ((in_byte_reg == ByteTermU) || is_func_term(in_byte_reg));
            if (out_ok_next) begin
                out_res_next.key_code   = (in_byte_reg == ByteTermU) ? first_reg
                                                                    : term_code(in_byte_reg);
                out_res_next.event_kind = KindPress;
                if (field_reg >= FieldMod) begin
                    if (mod_reg != 32'd0) begin
                        out_res_next.modifier_bits = mod_reg[7:0] - 8'd1;
                    end
                    if (has_sub_reg && (sub_low >= {6'd0, KindPress}) &&
                        (sub_low <= {6'd0, KindRelease})) begin
                        out_res_next.event_kind = sub_low[1:0];
                    end
                end
            end
            // back to reset state for the next sequence
            pos_next     = 3'd0;
            hdr_ok_next  = 1'b1;
            field_next   = FieldKey;
            first_next   = '0;
            mod_next     = '0;
            sub_next     = '0;
            has_sub_next = 1'b0;
            in_sub_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
            hdr_ok_reg    <= 1'b1;
            field_reg     <= FieldKey;
            first_reg     <= '0;
            mod_reg       <= '0;
            sub_reg       <= '0;
            has_sub_reg   <= 1'b0;
            in_sub_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= proc_fire && in_last_reg;
            end
            if (proc_fire) begin
                pos_reg     <= pos_next;
                hdr_ok_reg  <= hdr_ok_next;
                field_reg   <= field_next;
                first_reg   <= first_next;
                mod_reg     <= mod_next;
                sub_reg     <= sub_next;
                has_sub_reg <= has_sub_next;
                in_sub_reg  <= in_sub_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && in_last_reg) begin
            out_ok_reg  <= out_ok_next;
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {{(DataWidth - $bits(key_result_t)){1'b0}}, out_res_reg};

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected sequence carries nonzero fields");

    a_kind_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[41:40] != 2'd0))
        else $error("accepted sequence with zero event kind");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_last_reg) |=> ((pos_reg == 3'd0) && (field_reg == FieldKey) &&
                                        hdr_ok_reg && !in_sub_reg && !has_sub_reg))
        else $error("parser state not cleared after final byte");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result stage is empty");

endmodule

>>> sim/csi_key_sequence_parser_unit_tb.sv
`timescale 1ns / 100ps

module csi_key_sequence_parser_unit_tb;
    import csi_ksp_pkg::*;

    localparam int          StallLimit = 2000;
    localparam int          HoldOff    = 300;

    // fixed key codes of the functional-key terminators
    localparam logic [31:0] CodeUp    = 32'd57417;
    localparam logic [31:0] CodeDown  = 32'd57420;
    localparam logic [31:0] CodeRight = 32'd57421;
    localparam logic [31:0] CodeLeft  = 32'd57419;
    localparam logic [31:0] CodeHome  = 32'd57423;
    localparam logic [31:0] CodeEnd   = 32'd57424;
    localparam logic [31:0] CodeF1    = 32'd57364;
    localparam logic [31:0] CodeF2    = 32'd57365;
    localparam logic [31:0] CodeF3    = 32'd57366;
    localparam logic [31:0] CodeF4    = 32'd57367;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [7:0]  mods;
        logic [1:0]  kind;
    } key_event_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;  // data_byte
    logic                 s_tlast  = 1'b0;   // final_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DataWidth-1:0] m_tdata;           // key_code, modifier_bits, event_kind
    logic                 m_tuser;           // seq_valid

    csi_key_sequence_parser_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // parser state as the block should hold it
    logic [2:0]  seq_pos;
    logic        hdr_good;
    logic [1:0]  field_no;
    logic [31:0] key_acc;
    logic [31:0] mod_acc;
    logic [31:0] sub_acc;
    logic        mod_sub_seen;
    logic        in_sub;

    key_event_t  pending_events[$];
    logic [7:0]  frame_bytes[$];
    string       func_terms = "ABCDEFGHPQRS";

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int valid_seen    = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    task automatic clear_parser();
        seq_pos      = '0;
        hdr_good     = 1'b1;
        field_no     = FieldKey;
        key_acc      = '0;
        mod_acc      = '0;
        sub_acc      = '0;
        mod_sub_seen = 1'b0;
        in_sub       = 1'b0;
    endtask

    // append one byte to the frame being built
    task automatic add_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    // update the parser state for one accepted byte, queue the key event on a final byte
    task automatic track_key_byte(input logic [7:0] b, input logic last);
        logic [31:0] digit;
        logic        is_u;
        logic        is_fn;
        key_event_t  ev;
        digit = 32'(b - ByteZero);
        if (seq_pos == 3'd0 && b != ByteEsc) hdr_good = 1'b0;
        if (seq_pos == 3'd1 && b != ByteLbrk) hdr_good = 1'b0;
        if (!last) begin
            if (seq_pos >= PosBody) begin
                if (b >= ByteZero && b <= ByteNine) begin
                    if (in_sub) begin
                        if (field_no == FieldMod) sub_acc = sub_acc * 32'd10 + digit;
                    end else if (field_no == FieldKey) begin
                        key_acc = key_acc * 32'd10 + digit;
                    end else if (field_no == FieldMod) begin
                        mod_acc = mod_acc * 32'd10 + digit;
                    end
                end else if (b == ByteColon) begin
                    if (field_no == FieldMod) mod_sub_seen = 1'b1;
                    in_sub = 1'b1;
                end else if (b == ByteSemi) begin
                    if (field_no < FieldMax) field_no = field_no + 2'd1;
                    in_sub = 1'b0;
                end
            end
            if (seq_pos < PosMax) seq_pos = seq_pos + 3'd1;
        end else begin
            is_u  = (b == ByteTermU);
            is_fn = (b >= "A" && b <= "H") || (b >= "P" && b <= "S");
            ev    = '0;
            if (seq_pos >= PosMinOk && hdr_good && (is_u || is_fn)) begin
                ev.valid = 1'b1;
                if (is_u) begin
                    ev.key = key_acc;
                end else begin
                    case (b)
                        "A":     ev.key = CodeUp;
                        "B":     ev.key = CodeDown;
                        "C":     ev.key = CodeRight;
                        "D":     ev.key = CodeLeft;
                        "H":     ev.key = CodeHome;
                        "F":     ev.key = CodeEnd;
                        "P":     ev.key = CodeF1;
                        "Q":     ev.key = CodeF2;
                        "R":     ev.key = CodeF3;
                        "S":     ev.key = CodeF4;
                        default: ev.key = '0;
                    endcase
                end
                ev.kind = KindPress;
                if (field_no >= FieldMod) begin
                    if (mod_acc != 0) ev.mods = 8'(mod_acc - 32'd1);
                    if (mod_sub_seen && sub_acc[7:0] >= 8'd1 && sub_acc[7:0] <= 8'd3)
                        ev.kind = sub_acc[1:0];
                end
            end
            pending_events = {pending_events, ev};
            clear_parser();
        end
    endtask

    task automatic send_key_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_key_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame_bytes(input logic [7:0] term);
        foreach (frame_bytes[i]) send_key_byte(frame_bytes[i], 1'b0);
        send_key_byte(term, 1'b1);
    endtask

    // ESC '[' body term
    task automatic send_csi(input string body, input logic [7:0] term);
        frame_bytes = {ByteEsc, ByteLbrk};
        for (int i = 0; i < body.len(); i++) add_byte(body[i]);
        send_frame_bytes(term);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        stop_sending();
        wait (pending_events.size() == 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic append_digits(input int count);
        for (int i = 0; i < count; i++) add_byte(8'(ByteZero + $urandom_range(0, 9)));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("ERROR %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // result checking and the idle watchdog
    always @(posedge aclk) begin
        key_result_t got;
        key_event_t  want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(key_result_t)-1:0];
                results_seen++;
                if (pending_events.size() == 0) begin
                    report_mismatch("result transaction with nothing pending", got.key_code,
                                    32'd0);
                end else begin
                    want = pending_events.pop_front();
                    if (want.valid) valid_seen++;
                    if (m_tuser !== want.valid)
                        report_mismatch("seq_valid", 32'(m_tuser), 32'(want.valid));
                    if (got.key_code !== want.key)
                        report_mismatch("key_code", got.key_code, want.key);
                    if (got.modifier_bits !== want.mods)
                        report_mismatch("modifier_bits", 32'(got.modifier_bits),
                                        32'(want.mods));
                    if (got.event_kind !== want.kind)
                        report_mismatch("event_kind", 32'(got.event_kind), 32'(want.kind));
                    if (m_tdata[DataWidth-1:$bits(key_result_t)] !== '0)
                        report_mismatch("tdata padding",
                                        32'(m_tdata[DataWidth-1:$bits(key_result_t)]), 32'd0);
                end
            end
            if (quiet_cycles >= StallLimit) begin
                $display("TIMEOUT: no transaction for %0d cycles, %0d results pending",
                         StallLimit, pending_events.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side ready, with an optional long hold-off counted here
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic test_rejected_sequences();
        send_csi("", ByteTermU);           // three bytes only
        frame_bytes = {8'h00, ByteLbrk, "1"};
        send_frame_bytes("A");             // first byte not ESC
        frame_bytes = {ByteEsc, 8'hFF, "1"};
        send_frame_bytes(ByteTermU);       // second byte not '['
        send_csi("1", "Z");                // unknown terminator
        send_key_byte(8'hFF, 1'b1);        // lone final byte
    endtask

    task automatic test_parameter_fields();
        send_csi("1;5:3", ByteTermU);
        // wrap of the key value, zero modifier, repeated ':', junk byte, third field
        send_csi("4294967297;0:2:1x;7", ByteTermU);
        send_csi("9:2;256:2", "E");
        send_csi(";1:0", "G");
    endtask

    task automatic test_terminators();
        for (int i = 0; i < func_terms.len(); i++) send_csi("", func_terms[i]);
    endtask

    task automatic send_random_sequence();
        int r;
        int n;
        logic [7:0] term;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            frame_bytes = {ByteEsc, ByteLbrk};
            n = $urandom_range(0, 9);
            append_digits(n < 1 ? 0 : (n < 8 ? $urandom_range(1, 3) : $urandom_range(10, 12)));
            if ($urandom_range(0, 9) == 0) begin
                add_byte(ByteColon);
                append_digits($urandom_range(1, 2));
            end
            if ($urandom_range(0, 99) < 70) begin
                add_byte(ByteSemi);
                n = $urandom_range(0, 9);
                append_digits(n < 8 ? $urandom_range(0, 3) : $urandom_range(9, 11));
                if ($urandom_range(0, 99) < 60) begin
                    add_byte(ByteColon);
                    add_byte(8'(ByteZero + $urandom_range(0, 4)));
                    if ($urandom_range(0, 9) == 0) begin
                        add_byte($urandom_range(0, 1) ? ByteColon : ByteZero);
                        append_digits($urandom_range(0, 3));
                    end
                end
                if ($urandom_range(0, 99) < 20) begin
                    add_byte(ByteSemi);
                    append_digits($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 1) add_byte(ByteColon);
                    append_digits($urandom_range(0, 2));
                end
            end
            if ($urandom_range(0, 99) < 15)
                frame_bytes.insert($urandom_range(2, frame_bytes.size()), 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            if (r < 40) term = ByteTermU;
            else if (r < 85) term = func_terms[$urandom_range(0, func_terms.len() - 1)];
            else term = 8'($urandom_range(0, 255));
            send_frame_bytes(term);
        end else if (r < 88) begin
            // short or damaged header
            n = $urandom_range(0, 4);
            frame_bytes = {};
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
            if (n > 0 && $urandom_range(0, 1) == 1) frame_bytes[0] = ByteEsc;
            if (n > 1 && $urandom_range(0, 1) == 1) frame_bytes[1] = ByteLbrk;
            send_frame_bytes($urandom_range(0, 1) ? ByteTermU
                                                  : func_terms[$urandom_range(0, 11)]);
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 1; i < n; i++)
                send_key_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            send_key_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_sequence();
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge aclk);
        hold_cycles = HoldOff;
        for (int i = 0; i < 12; i++) send_csi("2;3", func_terms[i]);
        wait_for_results();
    endtask

    initial begin
        clear_parser();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_rejected_sequences();
        test_parameter_fields();
        test_terminators();
        wait_for_results();
        test_result_backpressure();

        send_idle_pct = 0;  stall_pct = 0;
        test_random_traffic(500);
        send_idle_pct = 48; stall_pct = 0;
        test_random_traffic(500);
        send_idle_pct = 0;  stall_pct = 48;
        test_random_traffic(500);
        send_idle_pct = 31; stall_pct = 31;
        test_random_traffic(500);

        $display("sent %0d bytes under four idle/stall mixes plus a long result hold-off",
                 bytes_sent);
        $display("checked %0d key results: %0d accepted, %0d rejected",
                 results_seen, valid_seen, results_seen - valid_seen);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
